// File: design/ppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_pkg: shared definitions for the packet payload protocol classifier
// Constants for the Ethernet, IPv4, TCP and UDP header layout, the result
// codes, the payload prefix table and the structs passed between modules.
// ----------------------------------------------------------------------------
package ppc_pkg;

	// Longest frame that is examined; later bytes are ignored.
	localparam int MAX_FRAME_BYTES = 65535;
	localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);

	// Header layout.
	localparam logic [15:0] MAC_HEADER_BYTES = 16'd14;
	localparam logic [15:0] IP_LEN_HI_INDEX  = 16'd16;
	localparam logic [15:0] IP_LEN_LO_INDEX  = 16'd17;
	localparam logic [15:0] IP_PROTO_INDEX   = 16'd23;
	localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;
	localparam logic [15:0] PORT_HI_OFFSET   = 16'd2;
	localparam logic [15:0] PORT_LO_OFFSET   = 16'd3;
	localparam logic [15:0] TCP_OFF_OFFSET   = 16'd12;
	localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
	localparam logic [7:0]  PROTO_TCP        = 8'd6;
	localparam logic [7:0]  PROTO_UDP        = 8'd17;

	// Well-known ports and markers.
	localparam logic [15:0] PORT_SMTP   = 16'd25;
	localparam logic [15:0] PORT_TELNET = 16'd23;
	localparam logic [7:0]  TELNET_IAC  = 8'hff;
	localparam logic [39:0] HTTP_TAG    = 40'h485454502F;
	localparam logic [15:0] HTTP_TAG_LEN = 16'd5;

	// Payload prefixes: GET, POST, 220, EHLO.
	localparam int PREFIX_CNT = 4;
	localparam int PFX_GET    = 0;
	localparam int PFX_POST   = 1;
	localparam int PFX_220    = 2;
	localparam int PFX_EHLO   = 3;
	localparam logic [2:0] PREFIX_LEN [PREFIX_CNT] = '{3'd4, 3'd5, 3'd4, 3'd4};

	typedef enum logic [2:0] {
		VERDICT_NONE   = 3'd0,
		VERDICT_HTTP   = 3'd1,
		VERDICT_SMTP   = 3'd2,
		VERDICT_TELNET = 3'd3,
		VERDICT_OTHER  = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		TRANS_TCP  = 2'd0,
		TRANS_UDP  = 2'd1,
		TRANS_NONE = 2'd2
	} transport_t;

	// Match status after the current byte, from the payload matcher.
	typedef struct packed {
		logic [15:0]           count;
		logic [PREFIX_CNT-1:0] prefix_hit;
		logic                  http_seen;
		logic                  first_iac;
	} match_status_t;

	// One classification result.
	typedef struct packed {
		logic [15:0] payload_bytes;
		logic [15:0] destination_port;
		transport_t  transport;
		verdict_t    verdict;
	} result_t;

	// Character p of prefix k.
	function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] p);
		logic [39:0] text;
		case (k)
			2'd0:    text = "GET  ";
			2'd1:    text = "POST ";
			2'd2:    text = "220  ";
			2'd3:    text = "EHLO ";
			default: text = 40'd0;
		endcase
		case (p)
			3'd0:    prefix_char = text[39:32];
			3'd1:    prefix_char = text[31:24];
			3'd2:    prefix_char = text[23:16];
			3'd3:    prefix_char = text[15:8];
			3'd4:    prefix_char = text[7:0];
			default: prefix_char = 8'd0;
		endcase
	endfunction

endpackage

// File: design/ppc_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_match: payload content matcher
// Tracks the payload byte count, the prefix candidates, a five-byte sliding
// window for the HTTP marker and the first payload byte of the frame.
// ----------------------------------------------------------------------------
module ppc_match import ppc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    data,
	input  logic          clear,
	output match_status_t status
);

	logic [15:0]           count_q;
	logic [31:0]           window_q;
	logic [PREFIX_CNT-1:0] flags_q;
	logic                  http_q;
	logic                  iac_q;

	logic [15:0]           count_nxt;
	logic [PREFIX_CNT-1:0] flags_nxt;
	logic                  http_nxt;
	logic                  iac_nxt;
	logic                  early;

	// Next match state with the current byte folded in.
	always_comb begin
		early     = (count_q < 16'd5);
		count_nxt = take ? count_q + 16'd1 : count_q;
		for (int k = 0; k < PREFIX_CNT; k++) begin
			flags_nxt[k] = flags_q[k] & ~(take && early &&
				(count_q[2:0] < PREFIX_LEN[k]) &&
				(data != prefix_char(2'(k), count_q[2:0])));
		end
		http_nxt = http_q | (take && (count_nxt >= HTTP_TAG_LEN) &&
			({window_q, data} == HTTP_TAG));
		iac_nxt  = (take && count_q == 16'd0) ? (data == TELNET_IAC) : iac_q;
	end

	// Status seen by the verdict logic.
	always_comb begin
		status.count     = count_nxt;
		status.http_seen = http_nxt;
		status.first_iac = iac_nxt;
		for (int k = 0; k < PREFIX_CNT; k++) begin
			status.prefix_hit[k] = flags_nxt[k] && (count_nxt >= 16'(PREFIX_LEN[k]));
		end
	end

	// Match registers, cleared at the end of every frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			window_q <= '0;
			flags_q  <= '1;
			http_q   <= 1'b0;
			iac_q    <= 1'b0;
		end else if (clear) begin
			count_q  <= '0;
			window_q <= '0;
			flags_q  <= '1;
			http_q   <= 1'b0;
			iac_q    <= 1'b0;
		end else if (take) begin
			count_q  <= count_nxt;
			window_q <= {window_q[23:0], data};
			flags_q  <= flags_nxt;
			http_q   <= http_nxt;
			iac_q    <= iac_nxt;
		end
	end

endmodule

// File: design/ppc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppc_parser: header field capture and verdict logic
// Counts frame bytes, captures the IPv4 and TCP/UDP header fields, marks the
// payload bytes for the matcher and forms the result on the last byte.
// ----------------------------------------------------------------------------
module ppc_parser import ppc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] data,
	input  logic       last,
	output result_t    result
);

	logic [IDX_W-1:0] idx_q;
	logic [3:0]       hw_q;
	logic [15:0]      total_q;
	logic [7:0]       proto_q;
	logic [15:0]      port_q;
	logic [3:0]       off_q;

	logic [15:0]      idx;
	logic             take;
	logic             frame_end;
	logic [3:0]       hw_eff;
	logic [15:0]      total_eff;
	logic [7:0]       proto_eff;
	logic [15:0]      port_eff;
	logic [3:0]       off_eff;
	logic [15:0]      tstart;
	logic [15:0]      thl;
	logic [15:0]      pstart;
	logic [16:0]      pend;
	logic             is_tcp;
	logic             is_udp;
	logic             geo_ok;
	logic             in_payload;
	logic [16:0]      idx_nxt;
	logic [15:0]      port_out;
	transport_t       trans;
	verdict_t         verdict;
	match_status_t    status;

	// Header fields, including the one carried by the current byte.
	always_comb begin
		idx       = 16'(idx_q);
		take      = byte_valid && (idx_q < IDX_W'(MAX_FRAME_BYTES));
		frame_end = byte_valid && last;
		hw_eff    = (take && idx == MAC_HEADER_BYTES) ? data[3:0] : hw_q;
		total_eff = total_q;
		if (take && idx == IP_LEN_HI_INDEX) total_eff[15:8] = data;
		if (take && idx == IP_LEN_LO_INDEX) total_eff[7:0] = data;
		proto_eff = (take && idx == IP_PROTO_INDEX) ? data : proto_q;
		tstart    = MAC_HEADER_BYTES + {10'd0, hw_eff, 2'b00};
		port_eff  = port_q;
		if (take && idx == tstart + PORT_HI_OFFSET) port_eff[15:8] = data;
		if (take && idx == tstart + PORT_LO_OFFSET) port_eff[7:0] = data;
		off_eff   = (take && idx == tstart + TCP_OFF_OFFSET) ? data[7:4] : off_q;
	end

	// Payload window: from the end of the transport header up to the IP length.
	always_comb begin
		is_tcp     = (proto_eff == PROTO_TCP);
		is_udp     = (proto_eff == PROTO_UDP);
		thl        = is_tcp ? {10'd0, off_eff, 2'b00} : UDP_HEADER_BYTES;
		geo_ok     = (hw_eff >= MIN_HEADER_WORDS) &&
			((is_tcp && off_eff >= MIN_HEADER_WORDS) || is_udp);
		pstart     = tstart + thl;
		pend       = {1'b0, total_eff} + {1'b0, MAC_HEADER_BYTES};
		in_payload = take && geo_ok && (idx >= pstart) && ({1'b0, idx} < pend);
	end

	ppc_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_payload),
		.data   (data),
		.clear  (frame_end),
		.status (status)
	);

	// Result for a frame that ends with the current byte.
	always_comb begin
		idx_nxt = take ? {1'b0, idx} + 17'd1 : {1'b0, idx};
		if (is_tcp)      trans = TRANS_TCP;
		else if (is_udp) trans = TRANS_UDP;
		else             trans = TRANS_NONE;
		port_out = (trans != TRANS_NONE && idx_nxt > {1'b0, tstart + PORT_LO_OFFSET}) ?
			port_eff : 16'd0;
		if (trans == TRANS_NONE || status.count == 16'd0)
			verdict = VERDICT_NONE;
		else if (status.prefix_hit[PFX_GET] || status.prefix_hit[PFX_POST] ||
				status.http_seen)
			verdict = VERDICT_HTTP;
		else if (port_out == PORT_SMTP || status.prefix_hit[PFX_220] ||
				status.prefix_hit[PFX_EHLO])
			verdict = VERDICT_SMTP;
		else if (port_out == PORT_TELNET || status.first_iac)
			verdict = VERDICT_TELNET;
		else
			verdict = VERDICT_OTHER;
		result.verdict          = verdict;
		result.transport        = trans;
		result.destination_port = port_out;
		result.payload_bytes    = (verdict == VERDICT_NONE) ? 16'd0 : status.count;
	end

	// Frame state, returned to reset at the end of every frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			hw_q    <= '0;
			total_q <= '0;
			proto_q <= '0;
			port_q  <= '0;
			off_q   <= '0;
		end else if (frame_end) begin
			idx_q   <= '0;
			hw_q    <= '0;
			total_q <= '0;
			proto_q <= '0;
			port_q  <= '0;
			off_q   <= '0;
		end else if (take) begin
			idx_q   <= idx_q + 1'b1;
			hw_q    <= hw_eff;
			total_q <= total_eff;
			proto_q <= proto_eff;
			port_q  <= port_eff;
			off_q   <= off_eff;
		end
	end

endmodule

// File: design/packet_payload_protocol_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_payload_protocol_classifier: IPv4 TCP/UDP payload classifier
// Classifies the payload of one captured Ethernet frame per run of bytes.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one frame byte per request, starting at the MAC
// header; s_tlast marks the final captured byte of a frame. One result
// request leaves on the master stream per frame, after its last byte.
// A byte is accepted in every cycle while the input stage is free or moving
// on, so a frame streams at one byte per clock. Each byte is held in the
// input register, then the header capture, payload matching and verdict
// logic run in a single pass into the state and the result register: the
// result is shown from the result register once the last byte leaves the input register.
// When the receiver stalls, the result waits in the output register while
// the input register still takes bytes; only a further last byte holds the
// input stage, and s_tready then falls until the output register drains.
// Reset clears the byte counter, all captured header fields, the matcher
// and both valid flags; the first byte after reset starts a new frame.
// ----------------------------------------------------------------------------
module packet_payload_protocol_classifier import ppc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // frame_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [2:0] verdict, [4:3] transport,
	                               // [20:5] destination_port, [36:21] payload_bytes
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    out_result_q;
	logic       adv_s1;
	result_t    result;

	// The input stage moves on unless it holds a last byte and the output is full and not read.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	ppc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (adv_s1),
		.data       (byte_s1),
		.last       (last_s1),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_result_q.payload_bytes, out_result_q.destination_port,
		out_result_q.transport, out_result_q.verdict};

endmodule
